>>> rtl/rdq_pkg.sv
`timescale 1ns / 1ps
package rdq_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_REAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_REAR  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic              en;
    logic [KIND_W-1:0] kind;
  } cell_ctrl_t;

endpackage

>>> rtl/rdq_cell.sv
`timescale 1ns / 1ps
module rdq_cell
  import rdq_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              sel_ins,
  input  logic              sel_out,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap
);

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.kind)
        KIND_INS_FRONT: data <= left_data;
        KIND_INS_REAR: begin
          if (sel_ins) begin
            data <= value;
          end
        end
        KIND_DEL_FRONT: data <= right_data;
        default: data <= data;
      endcase
    end
  end

  assign tap = sel_out ? data : '0;

endmodule

>>> rtl/ring_buffer_deque_core.sv
// double-ended queue built as a row of 64 value cells, front item in cell 0
// input channel s_axis: tuser carries the request kind (insert front, insert
//   rear, delete front, delete rear), tdata carries the value to insert
// output channel m_axis: one word per request; tuser is the status (done,
//   full, empty), tdata holds the removed value and the occupancy after it
// configuration: cfg_we with cfg_wdata sets the ring capacity (clamped to
//   1..64) and empties the deque; write only while no request is in flight
// latency: the result word is valid one cycle after the request is taken
// throughput: one request per cycle; front operations shift every cell by
//   one place, rear operations touch the cell picked by the occupancy count
// stall: the result sits in the output register until m_axis_tready; a new
//   request is taken in the same cycle the pending word leaves
// reset: capacity returns to 64, the deque is empty, no result is pending
`timescale 1ns / 1ps
module ring_buffer_deque_core
  import rdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // value
  input  logic [KIND_W-1:0] s_axis_tuser,   // kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // removed_value, occupancy, zero pad
  output logic [STAT_W-1:0] m_axis_tuser    // status
);

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  ring_n;
  logic [STAT_W-1:0] status;
  logic [STAT_W-1:0] status_next;
  logic [DATA_W-1:0] removed;
  logic [DATA_W-1:0] removed_next;
  logic [CNT_W-1:0]  occupancy;
  logic              out_valid;
  logic              take;
  logic              is_ins;
  logic              full;
  logic              empty;
  logic              ok;
  logic [DATA_W-1:0] rear_data;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tap  [DEPTH];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (capacity == '0) begin
      ring_n = CNT_W'(1);
    end else if (capacity > CNT_W'(DEPTH)) begin
      ring_n = CNT_W'(DEPTH);
    end else begin
      ring_n = capacity;
    end
  end

  assign is_ins = (s_axis_tuser == KIND_INS_FRONT) || (s_axis_tuser == KIND_INS_REAR);
  assign full   = (count == ring_n);
  assign empty  = (count == '0);
  assign ok     = is_ins ? !full : !empty;

  assign ctrl.en   = take && ok;
  assign ctrl.kind = s_axis_tuser;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
        assign left_data = s_axis_tdata;
      end else begin : g_mid
        assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_data = '0;
      end else begin : g_inner
        assign right_data = cell_data[i+1];
      end
      rdq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .sel_ins    (count == CNT_W'(i)),
        .sel_out    (count == CNT_W'(i + 1)),
        .value      (s_axis_tdata),
        .left_data  (left_data),
        .right_data (right_data),
        .data       (cell_data[i]),
        .tap        (cell_tap[i])
      );
    end
  endgenerate

  always_comb begin
    rear_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rear_data = rear_data | cell_tap[k];
    end
  end

  always_comb begin
    count_next   = count;
    status_next  = STAT_DONE;
    removed_next = '0;
    if (!ok) begin
      status_next = is_ins ? STAT_FULL : STAT_EMPTY;
    end else begin
      unique case (s_axis_tuser) inside
        KIND_INS_FRONT, KIND_INS_REAR: count_next = count + CNT_W'(1);
        KIND_DEL_FRONT: begin
          count_next   = count - CNT_W'(1);
          removed_next = cell_data[0];
        end
        default: begin
          count_next   = count - CNT_W'(1);
          removed_next = rear_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
        count    <= '0;
      end else if (take) begin
        count <= count_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status    <= status_next;
      removed   <= removed_next;
      occupancy <= count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = status;
  assign m_axis_tdata  = {1'b0, occupancy, removed};

endmodule
